// ===== design/sct_pkg.sv =====
`timescale 1ns / 1ps
package sct_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 32;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_MERGE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // one table entry; keep marks a live entry while the table streams round
  typedef struct packed {
    logic              keep;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } chunk_t;

  // what a cell shows its right-hand neighbour
  typedef struct packed {
    chunk_t chunk;
    logic   sh;
    logic   ge;
  } link_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_SHIFT,
    CM_SORT_EVEN,
    CM_SORT_ODD
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic              use_index;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [5:0]        eidx;
  } cell_ctrl_t;

endpackage

// ===== design/sct_cell.sv =====
`timescale 1ns / 1ps
module sct_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  sct_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]     count_i,
  input  logic              hit_i,
  input  sct_pkg::link_t    left_i,
  input  sct_pkg::chunk_t   right_i,
  output sct_pkg::link_t    link_o,
  output logic              first_o
);
  import sct_pkg::*;

  localparam bit EVEN_CELL = (IDX % 2) == 0;

  chunk_t cur_r;
  chunk_t cur_nxt;
  logic   live;
  logic   ge;
  logic   sh;
  logic   eq;
  logic   rm_shift;
  logic   pair_left;

  // local compares against the broadcast key
  always_comb begin
    live     = 32'(IDX) < 32'(count_i);
    ge       = live && (cur_r.start >= ctrl_i.addr);
    sh       = (live && (ctrl_i.addr < cur_r.start)) || (32'(IDX) == 32'(count_i));
    eq       = live && (cur_r.start == ctrl_i.addr);
    first_o  = ctrl_i.use_index ? (live && (32'(IDX) == 32'(ctrl_i.eidx)))
                                : (eq && !left_i.ge);
    rm_shift = ctrl_i.use_index ? (32'(IDX) >= 32'(ctrl_i.eidx)) : ge;
    pair_left = EVEN_CELL == (ctrl_i.mode == CM_SORT_EVEN);
  end

  assign link_o = '{chunk: cur_r, sh: sh, ge: ge};

  // next contents of the cell
  always_comb begin
    cur_nxt = cur_r;
    unique case (ctrl_i.mode)
      CM_HOLD: cur_nxt = cur_r;
      CM_INSERT: begin
        if (sh) begin
          if (left_i.sh) begin
            cur_nxt = left_i.chunk;
          end else begin
            cur_nxt = '{keep: 1'b1, start: ctrl_i.addr, size: ctrl_i.size};
          end
        end
      end
      CM_REMOVE: begin
        if (hit_i && rm_shift) begin
          cur_nxt = right_i;
        end
      end
      CM_SHIFT: cur_nxt = right_i;
      CM_SORT_EVEN, CM_SORT_ODD: begin
        if (pair_left) begin
          if (!cur_r.keep && right_i.keep) begin
            cur_nxt = right_i;
          end
        end else if (!left_i.chunk.keep && cur_r.keep) begin
          cur_nxt = left_i.chunk;
        end
      end
      default: cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// ===== design/sct_chain.sv =====
`timescale 1ns / 1ps
module sct_chain #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7,
  parameter int IW       = 6
) (
  input  logic                clk,
  input  sct_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  logic                hit_i,
  input  sct_pkg::chunk_t     tail_i,
  output sct_pkg::chunk_t     head_o,
  output logic                first_any_o,
  output logic [IW-1:0]       first_idx_o,
  output sct_pkg::chunk_t     first_chunk_o
);
  import sct_pkg::*;

  link_t  links [CAPACITY];
  logic   first [CAPACITY];
  link_t  lefts [CAPACITY];
  chunk_t rights [CAPACITY];

  // neighbour wiring; the front cell sees a live entry that never shifts
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        lefts[i] = '{chunk: '{keep: 1'b1, start: '0, size: '0}, sh: 1'b0, ge: 1'b0};
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        rights[i] = tail_i;
      end else begin
        rights[i] = links[i+1].chunk;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sct_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .hit_i   (hit_i),
      .left_i  (lefts[g]),
      .right_i (rights[g]),
      .link_o  (links[g]),
      .first_o (first[g])
    );
  end

  assign head_o = links[0].chunk;

  // at most one cell flags the hit, so plain or-reduction selects it
  always_comb begin
    first_any_o   = 1'b0;
    first_idx_o   = '0;
    first_chunk_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        first_any_o   = 1'b1;
        first_idx_o   = first_idx_o | IW'(i);
        first_chunk_o = first_chunk_o | links[i].chunk;
      end
    end
  end

endmodule

// ===== design/sorted_chunk_table.sv =====
`timescale 1ns / 1ps
// insert, query and remove: the cell row updates at transfer; the result is registered for the next cycle
// merge: streams the table past the adder, then a flush state, then odd-even
//   compaction of the kept entries, then the result
// a new item is taken once the previous one is finished and the result slot is free
// synchronous active-low reset empties the table; entry contents are not cleared
module sorted_chunk_table #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic [sct_pkg::ADDR_W-1:0] in_start_address,
  input  logic [sct_pkg::SIZE_W-1:0] in_chunk_size,
  input  logic                     in_by_index,
  input  logic [5:0]               in_entry_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [sct_pkg::IDX_OUT_W-1:0] out_found_index,
  output logic [sct_pkg::ADDR_W-1:0] out_removed_start,
  output logic [sct_pkg::SIZE_W-1:0] out_removed_size,
  output logic [sct_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import sct_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STREAM,
    S_FLUSH,
    S_SORT,
    S_DONE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] mcnt_r;
  logic [CW-1:0] k_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic [IDX_OUT_W-1:0] found_r;
  logic [IDX_OUT_W-1:0] found_nxt;
  logic [ADDR_W-1:0] rstart_r;
  logic [ADDR_W-1:0] rstart_nxt;
  logic [SIZE_W-1:0] rsize_r;
  logic [SIZE_W-1:0] rsize_nxt;
  logic [CNT_OUT_W-1:0] ecount_r;
  logic [CNT_OUT_W-1:0] ecount_nxt;
  chunk_t        h_r;
  chunk_t        h_nxt;

  cell_ctrl_t    ctrl;
  logic          hit;
  chunk_t        tail;
  chunk_t        head;
  logic          first_any;
  logic [IW-1:0] first_idx;
  chunk_t        first_chunk;

  logic          accept;
  logic          out_free;
  logic          full;
  logic          xv;
  logic          adj;
  logic [SIZE_W:0] end_sum;
  logic [SIZE_W:0] joined;
  chunk_t        emit;
  logic          k_last;

  assign out_free = !(out_valid_r && out_stall);
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = 32'(count_r) >= 32'(CAPACITY);
  assign k_last   = 32'(k_r) == 32'(CAPACITY - 1);

  // merge stream: head entry against the run being built in h_r
  always_comb begin
    xv      = k_r < mcnt_r;
    end_sum = {1'b0, h_r.start} + {1'b0, h_r.size};
    adj     = h_r.keep && xv && (end_sum == {1'b0, head.start});
    joined  = {1'b0, h_r.size} + {1'b0, head.size};
    h_nxt   = h_r;
    emit    = h_r;
    if (xv) begin
      if (adj) begin
        h_nxt.size = joined[SIZE_W] ? '1 : joined[SIZE_W-1:0];
        emit.keep  = 1'b0;
      end else begin
        h_nxt      = head;
        h_nxt.keep = 1'b1;
      end
    end else begin
      h_nxt.keep = 1'b0;
    end
  end

  // cell row control
  always_comb begin
    ctrl      = '{mode: CM_HOLD, use_index: 1'b0, addr: in_start_address,
                  size: in_chunk_size, eidx: in_entry_index};
    tail      = '{keep: 1'b0, start: '0, size: '0};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: ctrl.mode = full ? CM_HOLD : CM_INSERT;
            OP_QUERY:  ctrl.mode = CM_HOLD;
            OP_REMOVE: begin
              ctrl.mode      = CM_REMOVE;
              ctrl.use_index = in_by_index;
            end
            OP_MERGE:  ctrl.mode = CM_HOLD;
            default:   ctrl.mode = CM_HOLD;
          endcase
        end
      end
      S_STREAM: begin
        ctrl.mode = CM_SHIFT;
        tail      = emit;
      end
      S_FLUSH: begin
        ctrl.mode = CM_SHIFT;
        tail      = h_r;
      end
      S_SORT:  ctrl.mode = k_r[0] ? CM_SORT_ODD : CM_SORT_EVEN;
      S_DONE:  ctrl.mode = CM_HOLD;
      default: ctrl.mode = CM_HOLD;
    endcase
  end

  assign hit = accept && (in_op == OP_REMOVE) && (count_r != '0) && first_any;

  sct_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .IW       (IW)
  ) u_chain (
    .clk           (clk),
    .ctrl_i        (ctrl),
    .count_i       (count_r),
    .hit_i         (hit),
    .tail_i        (tail),
    .head_o        (head),
    .first_any_o   (first_any),
    .first_idx_o   (first_idx),
    .first_chunk_o (first_chunk)
  );

  // entry count after the current cycle
  always_comb begin
    count_nxt = count_r;
    if (accept && (in_op == OP_INSERT) && !full) begin
      count_nxt = count_r + CW'(1);
    end else if (hit) begin
      count_nxt = count_r - CW'(1);
    end else if ((state_r == S_STREAM) && adj) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // result payload for the next cycle
  always_comb begin
    status_nxt = status_r;
    found_nxt  = found_r;
    rstart_nxt = rstart_r;
    rsize_nxt  = rsize_r;
    ecount_nxt = ecount_r;
    if (accept) begin
      status_nxt = ST_OK;
      found_nxt  = '0;
      rstart_nxt = '0;
      rsize_nxt  = '0;
      ecount_nxt = CNT_OUT_W'(count_nxt);
      unique case (in_op)
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end
        end
        OP_QUERY: begin
          if (first_any) begin
            found_nxt = IDX_OUT_W'(first_idx);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        OP_REMOVE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (first_any) begin
            rstart_nxt = first_chunk.start;
            rsize_nxt  = first_chunk.size;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        OP_MERGE: status_nxt = ST_OK;
        default:  status_nxt = ST_OK;
      endcase
    end else if ((state_r == S_DONE) && out_free) begin
      ecount_nxt = CNT_OUT_W'(count_r);
    end
  end

  // result valid for the next cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && (in_op != OP_MERGE)) begin
      out_valid_nxt = 1'b1;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // sequencer, counters, result registers and merge run register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mcnt_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      found_r     <= '0;
      rstart_r    <= '0;
      rsize_r     <= '0;
      ecount_r    <= '0;
      h_r.keep    <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      rstart_r    <= rstart_nxt;
      rsize_r     <= rsize_nxt;
      ecount_r    <= ecount_nxt;
      if (accept) begin
        h_r.keep <= 1'b0;
      end else if (state_r == S_STREAM) begin
        h_r <= h_nxt;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_op == OP_MERGE)) begin
            state_r <= S_STREAM;
            mcnt_r  <= count_r;
            k_r     <= '0;
          end
        end
        S_STREAM: begin
          if (k_last) begin
            state_r <= S_FLUSH;
          end
          k_r <= k_last ? '0 : k_r + CW'(1);
        end
        S_FLUSH: begin
          state_r <= S_SORT;
          k_r     <= '0;
        end
        S_SORT: begin
          if (k_last) begin
            state_r <= S_DONE;
          end
          k_r <= k_last ? '0 : k_r + CW'(1);
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_index   = found_r;
  assign out_removed_start = rstart_r;
  assign out_removed_size  = rsize_r;
  assign out_entry_count   = ecount_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_INSERT) && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not add an entry");

  a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) |=> (count_r <= $past(count_r)))
    else $error("merge grew the table");

  a_merge_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STREAM) && !out_valid_r) |=> !out_valid_r)
    else $error("result transfer raised during merge stream");

endmodule
